>>> hdl/tet_pkg.sv
// Shared types, constants and register codes for the touch event tracker.
// Used by the interfaces and every module of the block; depends on nothing.
`default_nettype none
package tet_pkg;

  // Screen geometry.
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;

  // Field widths.
  localparam int RAW_W   = 12;
  localparam int TIME_W  = 32;
  localparam int EV_W    = 2;
  localparam int SX_W    = 9;
  localparam int SY_W    = 8;
  localparam int OFS_W   = 16;
  localparam int SCL_W   = 24;
  localparam int ORI_W   = 3;
  localparam int MS_W    = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int FRAC_W  = 16;

  // Datapath widths: offset-corrected raw value, scaled product, mirrored value.
  localparam int DIFF_W  = OFS_W + 1;
  localparam int PROD_W  = DIFF_W + SCL_W;
  localparam int MIR_W   = PROD_W + 1;
  localparam int COORD_W = 12;

  // Clamp limits in whole pixels and mirror origins in Q.16.
  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(SCREEN_W - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(SCREEN_H - 1);
  localparam logic signed [MIR_W-1:0] X_TOP = MIR_W'(longint'(SCREEN_W - 1) * 65536);
  localparam logic signed [MIR_W-1:0] Y_TOP = MIR_W'(longint'(SCREEN_H - 1) * 65536);

  // Queue between the front and back halves.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Event codes.
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [EV_W-1:0] EV_HOLD    = 2'd2;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_X_OFFSET     = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET     = 3'd1;
  localparam logic [2:0] REG_X_SCALE      = 3'd2;
  localparam logic [2:0] REG_Y_SCALE      = 3'd3;
  localparam logic [2:0] REG_ORIENTATION  = 3'd4;
  localparam logic [2:0] REG_PRESSURE_MIN = 3'd5;
  localparam logic [2:0] REG_DEBOUNCE_MS  = 3'd6;
  localparam logic [2:0] REG_HOLD_MS      = 3'd7;

  // Configuration register set.
  typedef struct packed {
    logic [OFS_W-1:0] x_offset;
    logic [OFS_W-1:0] y_offset;
    logic [SCL_W-1:0] x_scale;
    logic [SCL_W-1:0] y_scale;
    logic [ORI_W-1:0] orientation;
    logic [RAW_W-1:0] pressure_min;
    logic [MS_W-1:0]  debounce_ms;
    logic [MS_W-1:0]  hold_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_offset:     OFS_W'(200),
    y_offset:     OFS_W'(200),
    x_scale:      SCL_W'(5825),
    y_scale:      SCL_W'(4369),
    orientation:  ORI_W'(0),
    pressure_min: RAW_W'(200),
    debounce_ms:  MS_W'(50),
    hold_ms:      MS_W'(800)
  };

  // Classified sample passed from the front half to the back half.
  typedef struct packed {
    logic              touched;
    logic [RAW_W-1:0]  pressure;
    logic [TIME_W-1:0] now_ms;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
  } item_t;

endpackage
`default_nettype wire

>>> hdl/tet_if.sv
// Valid/ready channel interfaces for touch samples and result beats.
// Depends on tet_pkg for field widths.
`default_nettype none
interface tet_sample_if;
  import tet_pkg::*;
  logic              valid;
  logic              ready;
  logic              touch_detected;
  logic [RAW_W-1:0]  raw_x;
  logic [RAW_W-1:0]  raw_y;
  logic [RAW_W-1:0]  raw_pressure;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, touch_detected, raw_x, raw_y, raw_pressure, now_ms,
                  input ready);
  modport sink (input valid, touch_detected, raw_x, raw_y, raw_pressure, now_ms,
                output ready);
endinterface

interface tet_result_if;
  import tet_pkg::*;
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_res;
  logic [SX_W-1:0]  screen_x;
  logic [SY_W-1:0]  screen_y;
  logic [RAW_W-1:0] pressure;
  logic             point_valid;

  modport source (output valid, event_res, screen_x, screen_y, pressure, point_valid,
                  input ready);
  modport sink (input valid, event_res, screen_x, screen_y, pressure, point_valid,
                output ready);
endinterface
`default_nettype wire

>>> hdl/touch_event_tracker.sv
// Touch event tracker: top level joining the register file, front half, queue
// and back half. Depends on tet_pkg, tet_if, tet_regs, tet_front, tet_queue, tet_back.
//
// The tracker takes one touch-panel sample per clock cycle on the sample channel
// while the result side keeps taking beats, and returns exactly one result beat
// per sample, in order, on the result channel: the event (none, press, hold or
// release) and the last mapped screen point. A sample is registered in the front
// stage, which holds the two registered scale multiplies, passes through a
// four-entry queue and leaves through the back half's output register; the two
// multipliers and the queue sustain one sample per cycle for as long as the
// result side keeps taking beats. Configuration registers sit at byte addresses
// 4*i on the APB-style port and must be written while no sample is in flight.
`default_nettype none
module touch_event_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tet_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tet_pkg::DATA_W-1:0] pwdata,
  output logic      [tet_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  tet_sample_if.sink                      sample,
  tet_result_if.source                    result
);
  import tet_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t back_item;
  logic  push;
  logic  q_ready;
  logic  q_valid;
  logic  pop;

  tet_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tet_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .sample  (sample),
    .push    (push),
    .q_ready (q_ready),
    .item    (front_item)
  );

  tet_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .q_ready (q_ready),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_item (back_item)
  );

  tet_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .item    (back_item),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

>>> hdl/tet_regs.sv
// APB-style configuration register file of the touch event tracker.
// Depends on tet_pkg for the register set and its reset values.
`default_nettype none
module tet_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tet_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tet_pkg::DATA_W-1:0] pwdata,
  output logic      [tet_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tet_pkg::cfg_t                   cfg
);
  import tet_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_OFFSET:     cfg.x_offset     <= pwdata[OFS_W-1:0];
        REG_Y_OFFSET:     cfg.y_offset     <= pwdata[OFS_W-1:0];
        REG_X_SCALE:      cfg.x_scale      <= pwdata[SCL_W-1:0];
        REG_Y_SCALE:      cfg.y_scale      <= pwdata[SCL_W-1:0];
        REG_ORIENTATION:  cfg.orientation  <= pwdata[ORI_W-1:0];
        REG_PRESSURE_MIN: cfg.pressure_min <= pwdata[RAW_W-1:0];
        REG_DEBOUNCE_MS:  cfg.debounce_ms  <= pwdata[MS_W-1:0];
        REG_HOLD_MS:      cfg.hold_ms      <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      REG_X_OFFSET:     prdata = DATA_W'(cfg.x_offset);
      REG_Y_OFFSET:     prdata = DATA_W'(cfg.y_offset);
      REG_X_SCALE:      prdata = DATA_W'(cfg.x_scale);
      REG_Y_SCALE:      prdata = DATA_W'(cfg.y_scale);
      REG_ORIENTATION:  prdata = DATA_W'(cfg.orientation);
      REG_PRESSURE_MIN: prdata = DATA_W'(cfg.pressure_min);
      REG_DEBOUNCE_MS:  prdata = DATA_W'(cfg.debounce_ms);
      REG_HOLD_MS:      prdata = DATA_W'(cfg.hold_ms);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/tet_front.sv
// Front half: accepts sample beats, applies the pressure gate, swaps axes and
// forms the registered scaled products. Depends on tet_pkg and tet_if.
`default_nettype none
module tet_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tet_pkg::cfg_t cfg,
  tet_sample_if.sink         sample,
  output logic               push,
  input  wire logic          q_ready,
  output tet_pkg::item_t     item
);
  import tet_pkg::*;

  logic                     stg_valid;
  logic                     take;
  logic [RAW_W-1:0]         ax;
  logic [RAW_W-1:0]         ay;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic signed [SCL_W-1:0]  scale_x;
  logic signed [SCL_W-1:0]  scale_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  // The stage frees up whenever its content moves into the queue.
  assign sample.ready = !stg_valid || q_ready;
  assign take         = sample.valid && sample.ready;
  assign push         = stg_valid && q_ready;

  // Optional axis swap, then offset correction.
  assign ax = cfg.orientation[0] ? sample.raw_y : sample.raw_x;
  assign ay = cfg.orientation[0] ? sample.raw_x : sample.raw_y;
  assign diff_x = $signed({{(DIFF_W-RAW_W){1'b0}}, ax})
                - $signed({cfg.x_offset[OFS_W-1], cfg.x_offset});
  assign diff_y = $signed({{(DIFF_W-RAW_W){1'b0}}, ay})
                - $signed({cfg.y_offset[OFS_W-1], cfg.y_offset});

  // Exact Q.16 products.
  assign scale_x = $signed(cfg.x_scale);
  assign scale_y = $signed(cfg.y_scale);
  assign prod_x  = diff_x * scale_x;
  assign prod_y  = diff_y * scale_y;

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (sample.ready) begin
      stg_valid <= sample.valid;
    end
  end

  // Stage payload; a light contact counts as no contact.
  always_ff @(posedge clk) begin
    if (take) begin
      item.touched  <= sample.touch_detected && (sample.raw_pressure >= cfg.pressure_min);
      item.pressure <= sample.raw_pressure;
      item.now_ms   <= sample.now_ms;
      item.prod_x   <= prod_x;
      item.prod_y   <= prod_y;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tet_queue.sv
// Short queue that decouples the front and back halves of the tracker.
// Depends on tet_pkg for the item type and depth.
`default_nettype none
module tet_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tet_pkg::item_t wr_item,
  output logic                q_ready,
  input  wire logic           pop,
  output logic                q_valid,
  output tet_pkg::item_t      rd_item
);
  import tet_pkg::*;

  item_t             store [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_ready = (count != QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign rd_item = store[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_item;
    end
  end

  // The front never pushes into a full queue and the back never pops an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QDEPTH)) || pop)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
`default_nettype wire

>>> hdl/tet_back.sv
// Back half: mirrors, truncates and clamps the products, runs the press, hold
// and release tracking and holds the result beat. Depends on tet_pkg and tet_if.
`default_nettype none
module tet_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tet_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  input  wire tet_pkg::item_t item,
  output logic                pop,
  tet_result_if.source        result
);
  import tet_pkg::*;

  // Tracking state.
  logic              was_touched;
  logic              hold_fired;
  logic [TIME_W-1:0] press_start;
  logic [TIME_W-1:0] last_press_time;
  logic [SX_W-1:0]   point_x;
  logic [SY_W-1:0]   point_y;
  logic [RAW_W-1:0]  point_pressure;
  logic              point_ok;

  logic              was_touched_next;
  logic              hold_fired_next;
  logic [TIME_W-1:0] press_start_next;
  logic [TIME_W-1:0] last_press_time_next;
  logic [SX_W-1:0]   point_x_next;
  logic [SY_W-1:0]   point_y_next;
  logic [RAW_W-1:0]  point_pressure_next;
  logic              point_ok_next;
  logic [EV_W-1:0]   ev;

  logic [COORD_W-1:0] map_x;
  logic [COORD_W-1:0] map_y;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  held;

  // Mirror about the far edge, truncate toward zero and clamp to the screen.
  function automatic logic [COORD_W-1:0] map_axis(
    input logic [PROD_W-1:0]       prod,
    input logic                    mirror,
    input logic signed [MIR_W-1:0] top,
    input logic [COORD_W-1:0]      lim
  );
    logic signed [MIR_W-1:0]    p;
    logic [MIR_W-FRAC_W-1:0]    q;
    p = $signed({prod[PROD_W-1], prod});
    if (mirror) begin
      p = top - p;
    end
    q = p[MIR_W-1:FRAC_W];
    if (p[MIR_W-1]) begin
      return '0;
    end else if (q > (MIR_W-FRAC_W)'(lim)) begin
      return lim;
    end
    return q[COORD_W-1:0];
  endfunction

  // A new beat enters when the output register is empty or being drained.
  assign pop = q_valid && (!result.valid || result.ready);

  assign map_x = map_axis(item.prod_x, cfg.orientation[1], X_TOP, X_MAX);
  assign map_y = map_axis(item.prod_y, cfg.orientation[2], Y_TOP, Y_MAX);
  assign gap   = item.now_ms - last_press_time;
  assign held  = item.now_ms - press_start;

  // Event decision and next tracking state for the item at the head of the queue.
  always_comb begin
    was_touched_next     = was_touched;
    hold_fired_next      = hold_fired;
    press_start_next     = press_start;
    last_press_time_next = last_press_time;
    point_x_next         = point_x;
    point_y_next         = point_y;
    point_pressure_next  = point_pressure;
    point_ok_next        = point_ok;
    ev                   = EV_NONE;

    if (item.touched) begin
      point_x_next        = map_x[SX_W-1:0];
      point_y_next        = map_y[SY_W-1:0];
      point_pressure_next = item.pressure;
      point_ok_next       = 1'b1;
    end

    if (item.touched && !was_touched) begin
      // A press too soon after the last one is ignored.
      if (gap >= TIME_W'(cfg.debounce_ms)) begin
        press_start_next     = item.now_ms;
        last_press_time_next = item.now_ms;
        hold_fired_next      = 1'b0;
        was_touched_next     = 1'b1;
        ev                   = EV_PRESS;
      end
    end else if (item.touched && was_touched) begin
      if (!hold_fired && held >= TIME_W'(cfg.hold_ms)) begin
        hold_fired_next = 1'b1;
        ev              = EV_HOLD;
      end
    end else if (!item.touched && was_touched) begin
      was_touched_next = 1'b0;
      point_ok_next    = 1'b0;
      ev               = EV_RELEASE;
    end
  end

  // Tracking state and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      was_touched     <= 1'b0;
      hold_fired      <= 1'b0;
      press_start     <= '0;
      last_press_time <= '0;
      point_x         <= '0;
      point_y         <= '0;
      point_pressure  <= '0;
      point_ok        <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (pop) begin
        was_touched     <= was_touched_next;
        hold_fired      <= hold_fired_next;
        press_start     <= press_start_next;
        last_press_time <= last_press_time_next;
        point_x         <= point_x_next;
        point_y         <= point_y_next;
        point_pressure  <= point_pressure_next;
        point_ok        <= point_ok_next;
        result.valid    <= 1'b1;
      end else if (result.ready) begin
        result.valid    <= 1'b0;
      end
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      result.event_res   <= ev;
      result.screen_x    <= point_x_next;
      result.screen_y    <= point_y_next;
      result.pressure    <= point_pressure_next;
      result.point_valid <= point_ok_next;
    end
  end

  // A press or hold always comes with a live point, a release never does.
  a_press_point: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_res == EV_PRESS || result.event_res == EV_HOLD)
      |-> result.point_valid)
    else $error("press or hold without a valid point");
  a_release_point: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.event_res == EV_RELEASE |-> !result.point_valid)
    else $error("release with a valid point");
  a_hold_needs_touch: assert property (@(posedge clk) disable iff (rst)
    hold_fired && !$past(hold_fired) && !$past(rst) |-> was_touched)
    else $error("hold fired outside a touch");

endmodule
`default_nettype wire
